### rtl/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Types, constants and the message classifier shared by the frame deframer.
// ----------------------------------------------------------------------------
package dfr_pkg;

    localparam int unsigned HDR_BYTES   = 8;
    localparam int unsigned HDR_CNT_W   = $clog2(HDR_BYTES);
    localparam int unsigned LIMIT_W     = 17;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP   = 17'h10000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd16384;

    // APB register map (byte address / 4)
    localparam int unsigned ADDR_W  = 3;
    localparam logic REG_MAX_FRAME  = 1'b0;

    // Message ids
    localparam logic [31:0] ID_LOGIN  = 32'd104;
    localparam logic [31:0] ID_MOVE   = 32'd202;
    localparam logic [31:0] ID_ATTACK = 32'd206;
    localparam logic [31:0] ID_CHAT   = 32'd302;
    localparam logic [31:0] ID_ERROR  = 32'd500;

    // Message kind codes
    localparam logic [2:0] KIND_LOGIN   = 3'd0;
    localparam logic [2:0] KIND_MOVE    = 3'd1;
    localparam logic [2:0] KIND_IGNORED = 3'd2;
    localparam logic [2:0] KIND_ERROR   = 3'd3;
    localparam logic [2:0] KIND_OTHER   = 3'd4;

    typedef struct packed {
        logic        closed;
        logic [2:0]  message_kind;
        logic        frame_last;
        logic        byte_valid;
        logic [7:0]  payload_data;
        logic [15:0] payload_length;
        logic [31:0] message_id;
    } dfr_rec_t;

    typedef struct packed {
        logic closed;
        logic in_payload;
    } dfr_status_t;

    function automatic logic [2:0] kind_of(input logic [31:0] id);
        logic [2:0] k;
        case (id)
            ID_LOGIN:          k = KIND_LOGIN;
            ID_MOVE:           k = KIND_MOVE;
            ID_ATTACK, ID_CHAT: k = KIND_IGNORED;
            ID_ERROR:          k = KIND_ERROR;
            default:           k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

### rtl/length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Splits a byte stream into id/length prefixed frames and tags payload beats.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle, sustained, while the result side keeps up.
// A result for an input beat is written into the result queue, then loaded into
//   the output register that drives m_; a full output register can hold it back.
// s_tready drops only while the QUEUE_DEPTH-entry result queue is full.
// Reset (aresetn low, synchronous): parser back to header, stream reopened,
//   queue and output emptied, max_frame_bytes back to 16384.
module length_prefixed_frame_deframer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dfr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input byte stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [55:0]                 m_tdata,   // [31:0] message_id,
                                                   // [47:32] payload_length,
                                                   // [55:48] payload_data
    output logic [4:0]                  m_tuser,   // [0] byte_valid,
                                                   // [3:1] message_kind, [4] closed
    output logic                        m_tlast    // frame_last
);
    import dfr_pkg::*;

    logic [LIMIT_W-1:0] max_frame_reg;
    logic               cfg_wr;

    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    dfr_rec_t           push_rec;
    dfr_rec_t           q_rec;
    dfr_rec_t           m_rec;
    dfr_status_t        status;

    // ---- configuration register ----
    // Written on the access phase; the limit is sampled at each header end.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_FRAME);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_reg <= LIMIT_RESET;
        end else if (cfg_wr) begin
            max_frame_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_FRAME) ? {{(32 - LIMIT_W){1'b0}}, max_frame_reg}
                                                : 32'd0;

    // ---- front: header parse and record build ----
    // Bytes arriving after a close are still taken (and dropped) while the queue
    // has room, so a dead stream adds no stall of its own to the upstream.
    dfr_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .max_frame_bytes (max_frame_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .q_full          (q_full),
        .push            (push),
        .rec             (push_rec),
        .status          (status)
    );

    // ---- decoupling queue ----
    dfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_rec  (push_rec),
        .pop     (pop),
        .rd_rec  (q_rec),
        .full    (q_full),
        .empty   (q_empty)
    );

    // ---- back: output register ----
    dfr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_rec    (q_rec),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_rec    (m_rec)
    );

    // pack result beat
    assign m_tdata = {m_rec.payload_data, m_rec.payload_length, m_rec.message_id};
    assign m_tuser = {m_rec.closed, m_rec.message_kind, m_rec.byte_valid};
    assign m_tlast = m_rec.frame_last;

    // ---- assertions ----
    // a record is never written into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("result pushed into full queue");

    // once closed, the stream stays closed until reset
    a_closed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        status.closed |=> status.closed)
        else $error("stream reopened without reset");

    // a result raised at header end is either an empty frame or the close
    a_header_result: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !status.in_payload |-> push_rec.frame_last || push_rec.closed)
        else $error("stray result at header end");

    // an error notification always closes the stream
    a_error_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        push && push_rec.frame_last && (push_rec.message_kind == KIND_ERROR)
            |-> push_rec.closed ##1 status.closed)
        else $error("error notification did not close the stream");

endmodule

### rtl/dfr_front.sv
// ----------------------------------------------------------------------------
// dfr_front
// Header parser: takes stream bytes, tracks frame state, builds result records.
// ----------------------------------------------------------------------------
module dfr_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [dfr_pkg::LIMIT_W-1:0]   max_frame_bytes,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          q_full,
    output logic                          push,
    output dfr_pkg::dfr_rec_t             rec,
    output dfr_pkg::dfr_status_t          status
);
    import dfr_pkg::*;

    logic [63:0]          hdr_reg, hdr_next;
    logic [HDR_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 in_payload_reg, in_payload_next;
    logic                 closed_reg, closed_next;
    logic [15:0]          left_reg, left_next;
    logic [31:0]          id_reg, id_next;
    logic [15:0]          len_reg, len_next;
    logic [2:0]           kind_reg, kind_next;

    logic                 accept;
    logic [63:0]          hdr_shift;
    logic [31:0]          hdr_id;
    logic [31:0]          hdr_len;
    logic [LIMIT_W-1:0]   limit;
    logic [32:0]          frame_total;
    logic                 oversize;
    logic [2:0]           hdr_kind;
    logic [15:0]          left_dec;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    assign hdr_shift   = {s_tdata, hdr_reg[63:8]};
    assign hdr_id      = hdr_shift[31:0];
    assign hdr_len     = hdr_shift[63:32];
    assign limit       = (max_frame_bytes > LIMIT_CAP) ? LIMIT_CAP : max_frame_bytes;
    assign frame_total = {1'b0, hdr_len} + 33'(HDR_BYTES);
    assign oversize    = frame_total > {16'b0, limit};
    assign hdr_kind    = kind_of(hdr_id);
    assign left_dec    = left_reg - 16'd1;

    always_comb begin
        hdr_next        = hdr_reg;
        cnt_next        = cnt_reg;
        in_payload_next = in_payload_reg;
        closed_next     = closed_reg;
        left_next       = left_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        kind_next       = kind_reg;
        push            = 1'b0;
        rec             = '0;
        if (accept && !closed_reg) begin
            if (!in_payload_reg) begin
                hdr_next = hdr_shift;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == HDR_CNT_W'(HDR_BYTES - 1)) begin
                    id_next            = hdr_id;
                    kind_next          = hdr_kind;
                    push               = 1'b1;
                    rec.message_id     = hdr_id;
                    if (oversize) begin
                        len_next    = '0;
                        rec.closed  = 1'b1;
                        closed_next = 1'b1;
                    end else begin
                        len_next = hdr_len[15:0];
                        if (hdr_len[15:0] == 16'd0) begin
                            rec.frame_last   = 1'b1;
                            rec.message_kind = hdr_kind;
                            rec.closed       = (hdr_kind == KIND_ERROR);
                            closed_next      = (hdr_kind == KIND_ERROR);
                        end else begin
                            push            = 1'b0;
                            in_payload_next = 1'b1;
                            left_next       = hdr_len[15:0];
                        end
                    end
                end
            end else begin
                left_next          = left_dec;
                push               = 1'b1;
                rec.message_id     = id_reg;
                rec.payload_length = len_reg;
                rec.payload_data   = s_tdata;
                rec.byte_valid     = 1'b1;
                if (left_dec == 16'd0) begin
                    rec.frame_last   = 1'b1;
                    rec.message_kind = kind_reg;
                    rec.closed       = (kind_reg == KIND_ERROR);
                    closed_next      = (kind_reg == KIND_ERROR);
                    in_payload_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            in_payload_reg <= 1'b0;
            closed_reg     <= 1'b0;
            left_reg       <= '0;
        end else begin
            cnt_reg        <= cnt_next;
            in_payload_reg <= in_payload_next;
            closed_reg     <= closed_next;
            left_reg       <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_reg  <= hdr_next;
        id_reg   <= id_next;
        len_reg  <= len_next;
        kind_reg <= kind_next;
    end

    assign status.closed     = closed_reg;
    assign status.in_payload = in_payload_reg;

endmodule

### rtl/dfr_queue.sv
// ----------------------------------------------------------------------------
// dfr_queue
// Small register FIFO of result records between parser and output stage.
// ----------------------------------------------------------------------------
module dfr_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  dfr_pkg::dfr_rec_t wr_rec,
    input  logic              pop,
    output dfr_pkg::dfr_rec_t rd_rec,
    output logic              full,
    output logic              empty
);
    import dfr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dfr_rec_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_rec  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule

### rtl/dfr_back.sv
// ----------------------------------------------------------------------------
// dfr_back
// Output register stage: drains the queue onto the result channel.
// ----------------------------------------------------------------------------
module dfr_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  dfr_pkg::dfr_rec_t q_rec,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dfr_pkg::dfr_rec_t m_rec
);
    import dfr_pkg::*;

    logic     valid_reg, valid_next;
    dfr_rec_t rec_reg;

    // refill whenever the output slot is empty or being taken
    assign pop = !q_empty && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rec_reg <= q_rec;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_rec    = rec_reg;

endmodule

### tb/sv/tb_length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// tb_length_prefixed_frame_deframer
// Self-checking bench for the length-prefixed frame deframer. Bytes go in on
// the s_ stream and are run through a local deframer model at the beat on which
// they are accepted. Each result beat on m_ is checked field by field against
// the oldest predicted beat. Both stream sides idle at random, the receiver
// holds off long enough to fill the block, and the frame size limit is
// reprogrammed over APB between phases. The stream is closed once, at the end,
// because only reset reopens it.
// ----------------------------------------------------------------------------
module tb_length_prefixed_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import dfr_pkg::*;

    localparam int DRAIN_CYCLES = 8;     // result latency plus queue slack
    localparam int STALL_LIMIT  = 2000;  // cycles with no beat before giving up
    localparam int RANDOM_BYTES = 560;

    typedef enum int {
        CLOSE_BY_ERROR,
        CLOSE_BY_OVERSIZE,
        CLOSE_BY_LOW_LIMIT
    } close_cause_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // [31:0] message_id, [47:32] payload_length,
                            // [55:48] payload_data
    logic [4:0]  m_tuser;   // [0] byte_valid, [3:1] message_kind, [4] closed
    logic        m_tlast;   // frame_last

    length_prefixed_frame_deframer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Deframer model state, mirrors the block after reset
    // ------------------------------------------------------------------------
    logic [63:0] hdr_shift   = '0;   // header bytes gathered so far
    int          hdr_seen    = 0;
    logic [31:0] cur_id      = '0;
    logic [15:0] cur_len     = '0;
    logic [15:0] left_bytes  = '0;   // non-zero while inside a payload
    bit          stream_shut = 1'b0;
    logic [16:0] frame_limit = LIMIT_RESET;

    dfr_rec_t expected_beats[$];

    int  fail_count  = 0;
    int  items_sent  = 0;
    bit  quiet       = 1'b0;  // no idling on either side while set
    int  rx_hold_req = 0;     // long receiver hold-off, in cycles

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Limit as the block applies it: anything above the cap acts as the cap.
    function automatic int eff_limit();
        return (frame_limit > LIMIT_CAP) ? int'(LIMIT_CAP) : int'(frame_limit);
    endfunction

    function automatic logic [2:0] classify_id(input logic [31:0] id);
        if (id == ID_LOGIN) return KIND_LOGIN;
        if (id == ID_MOVE) return KIND_MOVE;
        if (id == ID_ATTACK || id == ID_CHAT) return KIND_IGNORED;
        if (id == ID_ERROR) return KIND_ERROR;
        return KIND_OTHER;
    endfunction

    // Mostly back-to-back, some short gaps, the odd long one.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // End of frame: tag with the kind, an error notification also shuts the stream.
    task automatic end_frame(input logic [7:0] data, input logic valid);
        dfr_rec_t r;
        r                = '0;
        r.message_id     = cur_id;
        r.payload_length = cur_len;
        r.payload_data   = data;
        r.byte_valid     = valid;
        r.frame_last     = 1'b1;
        r.message_kind   = classify_id(cur_id);
        r.closed         = (r.message_kind == KIND_ERROR);
        if (r.closed) stream_shut = 1'b1;
        left_bytes = '0;
        expected_beats.insert(expected_beats.size(), r);
    endtask

    // Advance the model by one accepted byte.
    task automatic deframe_byte(input logic [7:0] b);
        dfr_rec_t    r;
        logic [63:0] total;
        if (stream_shut) return;
        if (left_bytes == 0) begin
            hdr_shift[8*hdr_seen +: 8] = b;
            hdr_seen++;
            if (hdr_seen < HDR_BYTES) return;
            cur_id   = hdr_shift[31:0];
            total    = {32'd0, hdr_shift[63:32]} + 64'd8;
            hdr_seen = 0;
            if (total > 64'(eff_limit())) begin
                // oversize: one close beat, everything but the id zeroed
                cur_len      = '0;
                r            = '0;
                r.message_id = cur_id;
                r.closed     = 1'b1;
                stream_shut  = 1'b1;
                hdr_shift    = '0;
                expected_beats.insert(expected_beats.size(), r);
                return;
            end
            cur_len    = hdr_shift[47:32];
            left_bytes = cur_len;
            hdr_shift  = '0;
            if (cur_len == 0) end_frame(8'h00, 1'b0);
            return;
        end
        left_bytes--;
        if (left_bytes == 0) begin
            end_frame(b, 1'b1);
        end else begin
            r                = '0;
            r.message_id     = cur_id;
            r.payload_length = cur_len;
            r.payload_data   = b;
            r.byte_valid     = 1'b1;
            expected_beats.insert(expected_beats.size(), r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Starts at a posedge, returns at the posedge on which the beat is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        deframe_byte(b);
    endtask

    task automatic send_header(input logic [31:0] id, input logic [31:0] len);
        for (int i = 0; i < 4; i++) send_byte(id[8*i +: 8]);
        for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
    endtask

    task automatic send_payload(input int n);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_frame(input logic [31:0] id, input int len);
        send_header(id, len);
        send_payload(len);
    endtask

    // Sender stops until every predicted beat is back, then lets the
    // pipeline drain in case header bytes are still in flight.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write_limit(input logic [16:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_FRAME, 2'b00};
        pwdata  <= {15'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        frame_limit = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Short hand-made frames at the reset limit: payload bytes at both
    // extremes, an empty payload and an all-ones id.
    task automatic test_directed_frames();
        send_header(ID_LOGIN, 2);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(ID_ATTACK, 0);
        send_frame(32'hFFFF_FFFF, 1);
        settle();
    endtask

    // Limits at the boundaries, a write in the middle of a payload and the
    // register above range.
    task automatic test_limit_settings();
        apb_write_limit(17'd8);          // only empty payloads fit
        send_frame(ID_CHAT, 0);
        settle();
        apb_write_limit(17'd40);
        send_frame(ID_MOVE, 32);          // exactly at the limit
        settle();
        // new limit mid-payload must not touch the frame already under way
        apb_write_limit(17'd1000);
        send_header(ID_LOGIN, 60);
        send_payload(30);
        settle();
        apb_write_limit(17'd20);
        send_payload(30);
        send_frame(ID_ATTACK, 12);
        settle();
        apb_write_limit(17'h1FFFF);      // acts as the cap
        send_frame($urandom, 100);
        settle();
        apb_write_limit(LIMIT_CAP);
        send_frame(ID_MOVE, 40);
        settle();
    endtask

    // Receiver holds off while the sender keeps offering, so the result
    // queue fills and s_tready has to drop.
    task automatic test_backpressure();
        quiet       = 1'b1;
        rx_hold_req = 300;
        send_frame(ID_LOGIN, 20);
        send_frame(32'h8000_0000, 20);
        send_frame(ID_CHAT, 20);
        quiet = 1'b0;
        settle();
    endtask

    task automatic test_random_traffic();
        int          stop_at;
        int          r;
        int          len;
        logic [31:0] id;
        stop_at = items_sent + RANDOM_BYTES;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                settle();
                r = $urandom_range(0, 9);
                if (r < 3)       apb_write_limit(17'($urandom_range(8, 40)));
                else if (r == 3) apb_write_limit(17'($urandom_range(65537, 131071)));
                else if (r == 4) apb_write_limit(LIMIT_CAP);
                else             apb_write_limit(17'($urandom_range(41, 65535)));
            end
            if ($urandom_range(0, 15) == 0) quiet = !quiet;
            r = $urandom_range(0, 99);
            if (r < 15)      id = ID_LOGIN;
            else if (r < 30) id = ID_MOVE;
            else if (r < 40) id = ID_ATTACK;
            else if (r < 50) id = ID_CHAT;
            else begin
                id = $urandom;
                if (id == ID_ERROR) id = ID_ERROR + 1;  // keep the stream open
            end
            r = $urandom_range(0, 99);
            if (r < 10)      len = 0;
            else if (r < 85) len = $urandom_range(1, 16);
            else if (r < 97) len = $urandom_range(17, 64);
            else             len = $urandom_range(65, 400);
            if (len > eff_limit() - 8) len = eff_limit() - 8;
            send_frame(id, len);
        end
        quiet = 1'b0;
        settle();
    endtask

    // Shuts the stream one of three ways, then checks that later bytes
    // are swallowed without a result.
    task automatic test_stream_close();
        close_cause_t cause;
        int           r;
        int           lim;
        logic [31:0]  len;
        cause = close_cause_t'($urandom_range(0, 2));
        case (cause)
            CLOSE_BY_ERROR: begin
                send_frame(ID_ERROR, $urandom_range(0, 6));
            end
            CLOSE_BY_OVERSIZE: begin
                apb_write_limit(17'($urandom_range(8, 131071)));
                lim = eff_limit();
                r   = $urandom_range(0, 2);
                if (r == 0)      len = lim - 7;          // one byte too many
                else if (r == 1) len = 32'hFFFF_FFFF;
                else             len = $urandom_range(lim - 7, 32'hFFFF_FFFF);
                send_header($urandom, len);
            end
            default: begin
                apb_write_limit(17'($urandom_range(0, 7)));
                send_frame(ID_LOGIN, 0);
            end
        endcase
        send_payload(24);
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus the long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int g;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req != 0) begin
                g           = rx_hold_req;
                rx_hold_req = 0;
                m_tready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end else begin
                g = pick_gap();
                if (g != 0) begin
                    m_tready <= 1'b0;
                    repeat (g - 1) @(negedge aclk);
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        dfr_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result beat, expected none, actual %0h/%0h/%0b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = expected_beats.pop_front();
                check_field("message_id", want.message_id, m_tdata[31:0]);
                check_field("payload_length", 32'(want.payload_length),
                            32'(m_tdata[47:32]));
                check_field("payload_data", 32'(want.payload_data),
                            32'(m_tdata[55:48]));
                check_field("byte_valid", 32'(want.byte_valid), 32'(m_tuser[0]));
                check_field("message_kind", 32'(want.message_kind),
                            32'(m_tuser[3:1]));
                check_field("closed", 32'(want.closed), 32'(m_tuser[4]));
                check_field("frame_last", 32'(want.frame_last), 32'(m_tlast));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without a beat on either side
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_frames();
        test_limit_settings();
        test_backpressure();
        test_random_traffic();
        test_stream_close();      // last: nothing reopens the stream

        if (expected_beats.size() != 0) begin
            fail_count++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, expected_beats.size());
        end
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
rtl/dfr_pkg.sv
rtl/dfr_front.sv
rtl/dfr_queue.sv
rtl/dfr_back.sv
rtl/length_prefixed_frame_deframer.sv
tb/sv/tb_length_prefixed_frame_deframer.sv
